### hdl/sfq_pkg.sv
// Shared types and codes for the sortable first-in first-out queue.
// Holds no logic of its own and depends on nothing.
package sfq_pkg;

	// Request opcodes.
	typedef enum logic [1:0] {
		OP_ENQUEUE = 2'd0,
		OP_DEQUEUE = 2'd1,
		OP_PEEK    = 2'd2,
		OP_SORT    = 2'd3
	} op_t;

	// Error codes reported with every result.
	typedef enum logic [1:0] {
		ERR_OK        = 2'd0,
		ERR_UNDERFLOW = 2'd1,
		ERR_OVERFLOW  = 2'd2
	} err_t;

	// What one storage cell does at the next clock edge.
	typedef enum logic [1:0] {
		CELL_HOLD      = 2'd0,
		CELL_LOAD      = 2'd1,
		CELL_TAKE_NEXT = 2'd2,
		CELL_TAKE_PREV = 2'd3
	} cell_cmd_t;

	// Controller states.
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_SORT = 1'b1
	} state_t;

endpackage

### hdl/sfq_cell.sv
// One storage cell of the queue: holds a word, loads, shifts or swaps with its neighbors.
// Depends on sfq_pkg for the cell command type.
module sfq_cell
	import sfq_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  cell_cmd_t             cmd,
	input  logic [DATA_WIDTH-1:0] push_word,
	input  logic [DATA_WIDTH-1:0] next_word,
	input  logic [DATA_WIDTH-1:0] prev_word,
	output logic [DATA_WIDTH-1:0] word_q,
	output logic                  greater_than_next
);

	// Signed comparison against the neighbor toward the tail.
	assign greater_than_next = $signed(word_q) > $signed(next_word);

	// Stored word; contents are meaningless until written.
	always_ff @(posedge clk) begin
		case (cmd)
			CELL_LOAD:      word_q <= push_word;
			CELL_TAKE_NEXT: word_q <= next_word;
			CELL_TAKE_PREV: word_q <= prev_word;
			default:        word_q <= word_q;
		endcase
	end

endmodule

### hdl/sortable_fifo_queue.sv
// Sortable first-in first-out queue built as a row of storage cells, cell 0 at the head.
// Enqueue, dequeue and peek: result in the cycle after the request; a new request every cycle
// while busy is low. Sort: DEPTH rounds of odd-even transposition in the cell row, with busy
// held high during the rounds. Results cannot be stalled by the receiver.
// Reset empties the queue and clears control state; cell contents stay undefined.
// Depends on sfq_pkg and sfq_cell.
module sortable_fifo_queue
	import sfq_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   opcode,
	input  logic [31:0]                  push_value,
	output logic                         result_valid,
	output logic [31:0]                  read_data,
	output logic                         read_valid,
	output logic [$clog2(DEPTH+1)-1:0]   entry_count,
	output logic                         is_empty,
	output logic [1:0]                   error_code
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int RW = $clog2(DEPTH);

	state_t                state_q, state_d;
	logic                  accept;
	logic                  sort_done;
	logic                  last_round;
	logic [RW-1:0]         round_q;
	logic [CW-1:0]         count_q;
	op_t                   op;
	logic                  is_full;
	logic                  none_held;
	logic [63:0]           push_ext;
	logic [63:0]           head_ext;
	logic [DATA_WIDTH-1:0] push_word;

	logic [DATA_WIDTH-1:0] cell_word [DEPTH];
	logic [DEPTH-1:0]      cell_gt;
	cell_cmd_t             cell_cmd  [DEPTH];

	logic                  result_valid_q;
	logic [31:0]           read_data_q;
	logic                  read_valid_q;
	err_t                  error_q;

	assign op         = op_t'(opcode);
	assign accept     = start && !busy;
	assign is_full    = count_q == CW'(DEPTH);
	assign none_held  = count_q == '0;
	assign last_round = round_q == RW'(DEPTH - 1);

	// Input word cut to the storage width; head sign-extended to the result width.
	assign push_ext  = {32'b0, push_value};
	assign push_word = push_ext[DATA_WIDTH-1:0];
	assign head_ext  = 64'($signed(cell_word[0]));

	// Controller state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, busy and end of sort.
	always_comb begin
		state_d   = state_q;
		busy      = 1'b0;
		sort_done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start && op == OP_SORT) begin
					state_d = ST_SORT;
				end
			end
			ST_SORT: begin
				busy = 1'b1;
				if (last_round) begin
					sort_done = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sort round counter; its low bit picks the odd or even pairing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= '0;
		end else if (state_q == ST_SORT && !last_round) begin
			round_q <= round_q + 1'b1;
		end else begin
			round_q <= '0;
		end
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (op == OP_ENQUEUE && !is_full) begin
				count_q <= count_q + 1'b1;
			end else if (op == OP_DEQUEUE && !none_held) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Per-cell commands: load at the tail, shift toward the head, or swap within a pair.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cmd
		logic pair_left;
		logic pair_right;

		assign pair_left  = (i + 1 < DEPTH) && ((i % 2) == int'(round_q[0]))
			&& (count_q > CW'(i + 1)) && cell_gt[i];
		if (i > 0) begin : g_right
			assign pair_right = (((i - 1) % 2) == int'(round_q[0]))
				&& (count_q > CW'(i)) && cell_gt[i-1];
		end else begin : g_head
			assign pair_right = 1'b0;
		end

		always_comb begin
			cell_cmd[i] = CELL_HOLD;
			if (state_q == ST_SORT) begin
				if (pair_left) begin
					cell_cmd[i] = CELL_TAKE_NEXT;
				end else if (pair_right) begin
					cell_cmd[i] = CELL_TAKE_PREV;
				end
			end else if (accept) begin
				if (op == OP_ENQUEUE && !is_full && count_q == CW'(i)) begin
					cell_cmd[i] = CELL_LOAD;
				end else if (op == OP_DEQUEUE && !none_held && i + 1 < DEPTH) begin
					cell_cmd[i] = CELL_TAKE_NEXT;
				end
			end
		end
	end

	// The row of cells; the ends see their own word as the missing neighbor.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] next_word;
		logic [DATA_WIDTH-1:0] prev_word;

		if (i + 1 < DEPTH) begin : g_next
			assign next_word = cell_word[i+1];
		end else begin : g_tail
			assign next_word = cell_word[i];
		end
		if (i > 0) begin : g_prev
			assign prev_word = cell_word[i-1];
		end else begin : g_head
			assign prev_word = cell_word[i];
		end

		sfq_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk               (clk),
			.cmd               (cell_cmd[i]),
			.push_word         (push_word),
			.next_word         (next_word),
			.prev_word         (prev_word),
			.word_q            (cell_word[i]),
			.greater_than_next (cell_gt[i])
		);
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= (accept && op != OP_SORT) || sort_done;
		end
	end

	// Result payload for each request.
	always_ff @(posedge clk) begin
		if (sort_done) begin
			read_data_q  <= '0;
			read_valid_q <= 1'b0;
			error_q      <= ERR_OK;
		end else if (accept) begin
			read_data_q  <= '0;
			read_valid_q <= 1'b0;
			error_q      <= ERR_OK;
			case (op)
				OP_ENQUEUE: begin
					if (is_full) begin
						error_q <= ERR_OVERFLOW;
					end
				end
				OP_DEQUEUE, OP_PEEK: begin
					if (none_held) begin
						error_q <= ERR_UNDERFLOW;
					end else begin
						read_data_q  <= head_ext[31:0];
						read_valid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign read_data    = read_data_q;
	assign read_valid   = read_valid_q;
	assign error_code   = error_q;
	assign entry_count  = count_q;
	assign is_empty     = none_held;

endmodule

### bench/sfq_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the sortable queue bench: tracks predicted queue contents and checks results.
// Depends on sfq_pkg for the opcode and error code types.
package sfq_tb_pkg;
	import sfq_pkg::*;

	// One expected result, at the widths of the result ports.
	typedef struct {
		logic [31:0] data;
		logic        valid;
		logic [4:0]  count;
		logic        empty;
		err_t        err;
	} queue_result_t;

	class queue_scoreboard;
		int unsigned capacity;
		logic signed [31:0] held[$];       // predicted contents, head at index 0
		queue_result_t awaited[$];         // results still to come, oldest first
		int unsigned fails;
		int unsigned requests;
		int unsigned sorts;
		int unsigned overflows;
		int unsigned underflows;
		int unsigned checked;

		function new(int unsigned depth);
			capacity = depth;
			fails = 0;
			requests = 0;
			sorts = 0;
			overflows = 0;
			underflows = 0;
			checked = 0;
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		// Apply one accepted request to the predicted queue and record its result.
		function void note_request(op_t op, logic [31:0] value);
			queue_result_t res;
			logic signed [31:0] swap_word;
			int n;
			res.data = '0;
			res.valid = 1'b0;
			res.err = ERR_OK;
			requests++;
			case (op)
				OP_ENQUEUE: begin
					if (held.size() >= capacity) begin
						res.err = ERR_OVERFLOW;
						overflows++;
					end else begin
						held.push_back(value);
					end
				end
				OP_DEQUEUE, OP_PEEK: begin
					if (held.size() == 0) begin
						res.err = ERR_UNDERFLOW;
						underflows++;
					end else begin
						res.data = held[0];
						res.valid = 1'b1;
						if (op == OP_DEQUEUE)
							void'(held.pop_front());
					end
				end
				default: begin
					// Ascending signed order from head to tail.
					sorts++;
					n = held.size();
					for (int i = 0; i + 1 < n; i++) begin
						for (int j = 0; j + 1 < n - i; j++) begin
							if (held[j] > held[j + 1]) begin
								swap_word = held[j];
								held[j] = held[j + 1];
								held[j + 1] = swap_word;
							end
						end
					end
				end
			endcase
			res.count = 5'(held.size());
			res.empty = (held.size() == 0);
			awaited.push_back(res);
		endfunction

		// Compare one result with the oldest expectation, field by field.
		function void check_result(logic [31:0] data, logic valid, logic [4:0] count,
				logic empty, logic [1:0] err);
			queue_result_t want;
			if (awaited.size() == 0) begin
				$error("result with nothing expected: read_data %h error_code %0d", data, err);
				fails++;
				return;
			end
			want = awaited.pop_front();
			checked++;
			if (data !== want.data) begin
				$error("read_data: expected %h, got %h", want.data, data);
				fails++;
			end
			if (valid !== want.valid) begin
				$error("read_valid: expected %0d, got %0d", want.valid, valid);
				fails++;
			end
			if (count !== want.count) begin
				$error("entry_count: expected %0d, got %0d", want.count, count);
				fails++;
			end
			if (empty !== want.empty) begin
				$error("is_empty: expected %0d, got %0d", want.empty, empty);
				fails++;
			end
			if (err !== want.err) begin
				$error("error_code: expected %0d, got %0d", want.err, err);
				fails++;
			end
		endfunction
	endclass

endpackage

### bench/sortable_fifo_queue_tb.sv
`timescale 1ns / 1ps
// Top-level bench for sortable_fifo_queue: directed and random requests with idle bursts.
// Depends on sfq_pkg, sfq_tb_pkg and the queue RTL.
module sortable_fifo_queue_tb;
	import sfq_pkg::*;
	import sfq_tb_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam int PHASES = 16;
	localparam int PHASE_LEN = 50;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 40;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  opcode;
	logic [31:0] push_value;
	logic        result_valid;
	logic [31:0] read_data;
	logic        read_valid;
	logic [4:0]  entry_count;
	logic        is_empty;
	logic [1:0]  error_code;

	queue_scoreboard sb;
	int unsigned quiet_cycles;

	sortable_fifo_queue #(
		.DEPTH(QUEUE_DEPTH),
		.DATA_WIDTH(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.push_value(push_value),
		.result_valid(result_valid),
		.read_data(read_data),
		.read_valid(read_valid),
		.entry_count(entry_count),
		.is_empty(is_empty),
		.error_code(error_code)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sample accepted requests and results on the clock edge, and watch for a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid)
				sb.check_result(read_data, read_valid, entry_count, is_empty, error_code);
			if (start && !busy)
				sb.note_request(op_t'(opcode), push_value);
			if ((start && !busy) || result_valid)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Watchdog: no progress for %0d cycles", STALL_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Present one request and hold it until the queue takes it.
	task automatic send_request(op_t op, logic [31:0] value);
		start <= 1'b1;
		opcode <= op;
		push_value <= value;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Leave start low for a number of cycles with junk on the payload.
	task automatic idle_for(int unsigned cycles);
		start <= 1'b0;
		opcode <= 2'($urandom);
		push_value <= $urandom;
		repeat (cycles) @(posedge clk);
	endtask

	// Hold off new requests until every outstanding result has come back.
	// The task waits for the current edge first so the request taken at it is already counted.
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Mix of extremes, small values with many repeats, and full random words.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'($signed($urandom_range(0, 20)) - 10);
			3: return ($urandom_range(0, 1) != 0) ? 32'h0 : 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Opcode drawn with a given share of enqueues so the fill level drifts up or down.
	function automatic op_t pick_op(int unsigned enq_pct);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < enq_pct)
			return OP_ENQUEUE;
		if (r < enq_pct + 8)
			return OP_SORT;
		return ($urandom_range(0, 2) == 2) ? OP_PEEK : OP_DEQUEUE;
	endfunction

	initial begin
		bit idling;
		sb = new(QUEUE_DEPTH);
		quiet_cycles = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		opcode <= OP_ENQUEUE;
		push_value <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reads and sort on an empty queue, extremes, one-entry sort, emptying.
		send_request(OP_DEQUEUE, 32'h0);
		send_request(OP_PEEK, 32'hffff_ffff);
		send_request(OP_SORT, 32'h0);
		send_request(OP_ENQUEUE, 32'h8000_0000);
		send_request(OP_PEEK, 32'h0);
		send_request(OP_SORT, 32'h0);
		send_request(OP_ENQUEUE, 32'h7fff_ffff);
		send_request(OP_ENQUEUE, 32'hffff_ffff);
		send_request(OP_ENQUEUE, 32'h0000_0000);
		send_request(OP_ENQUEUE, 32'h0000_0001);
		send_request(OP_SORT, 32'h0);
		send_request(OP_PEEK, 32'h0);
		repeat (5) send_request(OP_DEQUEUE, 32'h0);
		send_request(OP_PEEK, 32'h0);

		// Random phases alternate between filling toward full and draining toward empty.
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase % 4 == 1)
				wait_drained();
			idling = (phase < PHASES - 2) && (phase % 3 != 2);
			for (int k = 0; k < PHASE_LEN; k++) begin
				if (idling && $urandom_range(0, 4) == 0)
					idle_for($urandom_range(1, 15));
				send_request(pick_op((phase % 2 == 0) ? 75 : 30), pick_word());
			end
		end

		// Let the last results come back, then allow time for any stray one.
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d requests including %0d sorts; %0d overflows and %0d underflows.",
			sb.requests, sb.sorts, sb.overflows, sb.underflows);
		$display("Checked %0d results with %0d mismatches.", sb.checked, sb.fails);
		if (sb.fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### sim.f
hdl/sfq_pkg.sv
hdl/sfq_cell.sv
hdl/sortable_fifo_queue.sv
bench/sfq_tb_pkg.sv
bench/sortable_fifo_queue_tb.sv
